FILE: hw/rtl/tscf_pkg.sv
// shared types, constants and microcode fields for the text stream cat filter
// no dependencies; imported by tscf_seq, tscf_dp and text_stream_cat_filter

package tscf_pkg;

    localparam int DIGITS_DEFAULT = 10;
    localparam int PAD_WIDTH      = 6;
    localparam int PAD_W          = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int BODY_MAX       = 4;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NONBLANK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_ALL       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd5;

    // character codes
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DOLLAR = 8'd36;
    localparam logic [7:0] CH_DASH   = 8'd45;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_QUEST  = 8'd63;
    localparam logic [7:0] CH_CAPI   = 8'd73;
    localparam logic [7:0] CH_CAPM   = 8'd77;
    localparam logic [7:0] CH_CARET  = 8'd94;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CARET_OFS = 8'd64;

    // microcode step addresses
    typedef logic [2:0] step_t;
    localparam step_t STEP_FETCH = 3'd0;
    localparam step_t STEP_PAD   = 3'd1;
    localparam step_t STEP_DIGIT = 3'd2;
    localparam step_t STEP_TAB   = 3'd3;
    localparam step_t STEP_BODY  = 3'd4;

    typedef enum logic [2:0] {
        SRC_INPUT,
        SRC_SPACE,
        SRC_DIGIT,
        SRC_TAB,
        SRC_BODY
    } src_t;

    typedef enum logic [1:0] {
        CNT_NONE,
        CNT_PAD,
        CNT_DIGIT,
        CNT_BODY
    } cnt_t;

    typedef enum logic [1:0] {
        J_NEXT,
        J_FETCH,
        J_DISPATCH
    } jump_t;

    // one control word
    typedef struct packed {
        src_t  src;
        cnt_t  cnt;
        jump_t jump;
        logic  inc_line;
    } ctrl_t;

    // datapath status back to the sequencer
    typedef struct packed {
        logic fire;
        logic done;
        logic drop;
        logic do_number;
    } stat_t;

    typedef struct packed {
        logic number_nonblank;
        logic number_all;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } cfg_t;

endpackage

FILE: hw/rtl/tscf_seq.sv
// microcode sequencer: step counter, control store and jump logic
// depends on tscf_pkg

module tscf_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  tscf_pkg::stat_t stat,
    output tscf_pkg::ctrl_t ctrl
);
    import tscf_pkg::*;

    step_t step_reg;
    step_t step_next;

    function automatic ctrl_t ucode(input step_t addr);
        ctrl_t w;
        begin
            w = '{src: SRC_INPUT, cnt: CNT_NONE, jump: J_DISPATCH, inc_line: 1'b0};
            unique case (addr)
                STEP_FETCH: w = '{src: SRC_INPUT, cnt: CNT_NONE,  jump: J_DISPATCH, inc_line: 1'b0};
                STEP_PAD:   w = '{src: SRC_SPACE, cnt: CNT_PAD,   jump: J_NEXT,     inc_line: 1'b0};
                STEP_DIGIT: w = '{src: SRC_DIGIT, cnt: CNT_DIGIT, jump: J_NEXT,     inc_line: 1'b0};
                STEP_TAB:   w = '{src: SRC_TAB,   cnt: CNT_NONE,  jump: J_NEXT,     inc_line: 1'b1};
                STEP_BODY:  w = '{src: SRC_BODY,  cnt: CNT_BODY,  jump: J_FETCH,    inc_line: 1'b0};
                default:    w = '{src: SRC_INPUT, cnt: CNT_NONE,  jump: J_FETCH,    inc_line: 1'b0};
            endcase
            return w;
        end
    endfunction

    assign ctrl = ucode(step_reg);

    always_comb
    begin
        step_next = step_reg;
        if (stat.fire && stat.done)
        begin
            unique case (ctrl.jump)
                J_NEXT:     step_next = step_t'(step_reg + 3'd1);
                J_FETCH:    step_next = STEP_FETCH;
                J_DISPATCH:
                begin
                    priority if (stat.drop)
                        step_next = STEP_FETCH;
                    else if (stat.do_number)
                        step_next = STEP_PAD;
                    else
                        step_next = STEP_BODY;
                end
                default:    step_next = STEP_FETCH;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_FETCH;
        else
            step_reg <= step_next;
    end

    a_drop_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_FETCH && stat.fire && stat.drop) |=> step_reg == STEP_FETCH)
        else $error("dropped line left the fetch step");

    a_number_path: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_TAB && stat.fire) |=> step_reg == STEP_BODY)
        else $error("tab step not followed by body");

endmodule

FILE: hw/rtl/tscf_dp.sv
// datapath: byte decode, line counter, expansion buffer and output register
// depends on tscf_pkg; driven by tscf_seq control words

module tscf_dp #(
    parameter int NUMBER_DIGITS = tscf_pkg::DIGITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  tscf_pkg::cfg_t  cfg,
    input  tscf_pkg::ctrl_t ctrl,
    output tscf_pkg::stat_t stat,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last
);
    import tscf_pkg::*;

    localparam int LINE_W = 4 * NUMBER_DIGITS;
    localparam int LEN_W  = $clog2(NUMBER_DIGITS + 1);
    localparam int IDX_W  = $clog2(NUMBER_DIGITS);

    logic              prev_nl_reg;
    logic [1:0]        blank_run_reg;
    logic [1:0]        blank_run_next;
    logic [LINE_W-1:0] line_reg;
    logic [LINE_W-1:0] line_next;
    logic [PAD_W-1:0]  pad_cnt_reg;
    logic [LEN_W-1:0]  dig_idx_reg;
    logic [7:0]        body_reg [BODY_MAX];
    logic [1:0]        body_idx_reg;
    logic [1:0]        body_last_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;

    logic              accept;
    logic              is_nl;
    logic              drop;
    logic              do_number;
    logic [LEN_W-1:0]  len;
    logic [PAD_W-1:0]  pad;
    logic [7:0]        body [BODY_MAX];
    logic [1:0]        body_last;
    logic              slot_free;
    logic              skip;
    logic              emit;
    logic              done;
    logic [7:0]        emit_byte;
    logic [IDX_W-1:0]  dig_sel;
    logic [3:0]        digit;
    logic [NUMBER_DIGITS-1:0] nine;
    logic [NUMBER_DIGITS-1:0] carry;
    logic [NUMBER_DIGITS-1:0] bcd_ok;

    // input decode
    assign in_ready = (ctrl.src == SRC_INPUT);
    assign accept   = in_ready && in_valid;
    assign is_nl    = (in_byte == CH_NL);

    always_comb
    begin
        if (is_nl && prev_nl_reg)
            blank_run_next = (blank_run_reg == 2'd3) ? 2'd3 : blank_run_reg + 2'd1;
        else
            blank_run_next = 2'd0;
        drop = cfg.squeeze_blank && blank_run_next[1];
        if (cfg.number_nonblank)
            do_number = prev_nl_reg && !is_nl;
        else
            do_number = prev_nl_reg && cfg.number_all;
    end

    // number length from the highest nonzero digit
    always_comb
    begin
        len = LEN_W'(1);
        for (int i = 1; i < NUMBER_DIGITS; i++)
        begin
            if (line_reg[4*i +: 4] != 4'd0)
                len = LEN_W'(i + 1);
        end
        if (len < LEN_W'(PAD_WIDTH))
            pad = PAD_W'(LEN_W'(PAD_WIDTH) - len);
        else
            pad = '0;
    end

    // expansion of the byte itself
    always_comb
    begin
        logic [7:0] low;
        logic [1:0] ofs;
        low = {1'b0, in_byte[6:0]};
        ofs = 2'd0;
        for (int i = 0; i < BODY_MAX; i++)
            body[i] = in_byte;
        body_last = 2'd0;
        priority if (is_nl)
        begin
            if (cfg.show_ends)
            begin
                body[0]   = CH_DOLLAR;
                body[1]   = CH_NL;
                body_last = 2'd1;
            end
        end
        else if (in_byte == CH_TAB)
        begin
            if (cfg.show_tabs)
            begin
                body[0]   = CH_CARET;
                body[1]   = CH_CAPI;
                body_last = 2'd1;
            end
        end
        else if (cfg.show_nonprinting && (in_byte < CH_SPACE || in_byte >= CH_DEL))
        begin
            if (in_byte[7])
            begin
                body[0] = CH_CAPM;
                body[1] = CH_DASH;
                ofs     = 2'd2;
            end
            priority if (low < CH_SPACE)
            begin
                body[ofs]          = CH_CARET;
                body[ofs + 2'd1]   = low + CARET_OFS;
                body_last          = ofs + 2'd1;
            end
            else if (low == CH_DEL)
            begin
                body[ofs]          = CH_CARET;
                body[ofs + 2'd1]   = CH_QUEST;
                body_last          = ofs + 2'd1;
            end
            else
            begin
                body[ofs]          = low;
                body_last          = ofs;
            end
        end
        else
        begin
            body[0] = in_byte;
        end
    end

    // saturating bcd increment
    always_comb
    begin
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            nine[i]   = (line_reg[4*i +: 4] == 4'd9);
            bcd_ok[i] = (line_reg[4*i +: 4] <= 4'd9);
        end
        carry[0] = 1'b1;
        for (int i = 1; i < NUMBER_DIGITS; i++)
            carry[i] = carry[i-1] && nine[i-1];
        line_next = line_reg;
        if (!(&nine))
        begin
            for (int i = 0; i < NUMBER_DIGITS; i++)
            begin
                if (carry[i])
                    line_next[4*i +: 4] = nine[i] ? 4'd0 : line_reg[4*i +: 4] + 4'd1;
            end
        end
    end

    // step execution
    assign dig_sel   = IDX_W'(dig_idx_reg - LEN_W'(1));
    assign digit     = line_reg[4*dig_sel +: 4];
    assign slot_free = !out_valid_reg || out_ready;
    assign skip      = (ctrl.src == SRC_SPACE) && (pad_cnt_reg == '0);

    always_comb
    begin
        unique case (ctrl.src)
            SRC_INPUT: emit_byte = CH_SPACE;
            SRC_SPACE: emit_byte = CH_SPACE;
            SRC_DIGIT: emit_byte = CH_ZERO | {4'd0, digit};
            SRC_TAB:   emit_byte = CH_TAB;
            SRC_BODY:  emit_byte = body_reg[body_idx_reg];
            default:   emit_byte = CH_SPACE;
        endcase
        unique case (ctrl.cnt)
            CNT_NONE:  done = 1'b1;
            CNT_PAD:   done = (pad_cnt_reg <= PAD_W'(1));
            CNT_DIGIT: done = (dig_idx_reg == LEN_W'(1));
            CNT_BODY:  done = (body_idx_reg == body_last_reg);
            default:   done = 1'b1;
        endcase
    end

    assign emit = (ctrl.src != SRC_INPUT) && !skip && slot_free;

    always_comb
    begin
        stat.done      = done;
        stat.drop      = drop;
        stat.do_number = do_number;
        if (ctrl.src == SRC_INPUT)
            stat.fire = accept;
        else
            stat.fire = skip || slot_free;
    end

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_nl_reg   <= 1'b1;
            blank_run_reg <= 2'd0;
            line_reg      <= {{(LINE_W-1){1'b0}}, 1'b1};
            pad_cnt_reg   <= '0;
            dig_idx_reg   <= LEN_W'(1);
            body_idx_reg  <= 2'd0;
            body_last_reg <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                blank_run_reg <= blank_run_next;
                if (!drop)
                    prev_nl_reg <= is_nl;
                pad_cnt_reg   <= pad;
                dig_idx_reg   <= len;
                body_idx_reg  <= 2'd0;
                body_last_reg <= body_last;
            end
            if (emit)
            begin
                unique case (ctrl.cnt)
                    CNT_NONE:  ;
                    CNT_PAD:   pad_cnt_reg  <= pad_cnt_reg - PAD_W'(1);
                    CNT_DIGIT: dig_idx_reg  <= dig_idx_reg - LEN_W'(1);
                    CNT_BODY:  body_idx_reg <= body_idx_reg + 2'd1;
                    default:   ;
                endcase
                if (ctrl.inc_line)
                    line_reg <= line_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < BODY_MAX; i++)
                body_reg[i] <= body[i];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= (ctrl.src == SRC_BODY) && done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
        &bcd_ok)
        else $error("line counter holds a digit above nine");

    a_digit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.src == SRC_DIGIT) |-> (dig_idx_reg != '0))
        else $error("digit step with empty digit index");

    a_body_index: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.src == SRC_BODY) |-> (body_idx_reg <= body_last_reg))
        else $error("body index ran past the last byte");

endmodule

FILE: hw/rtl/text_stream_cat_filter.sv
// top level of the text stream cat filter: config registers, sequencer and datapath
// depends on tscf_pkg, tscf_seq, tscf_dp
//
//  channel   signals                                   beat
//  s_axis    tvalid tready tdata[7:0]                  one raw text byte
//  m_axis    tvalid tready tdata[7:0] tlast            one output byte, tlast on last of a byte
//  cfg       cfg_we cfg_index[2:0] cfg_data[0]         one register write
//
// an input byte takes a fetch step, then its expanded bytes are emitted by the body step
// a numbered line start adds a pad step (one space per pad count), a digit step (one per digit)
// and a tab step; the single shared output register sets the one-beat-per-cycle pace
// while m_axis is ready; a dropped blank line uses only its fetch step
// reset: line counter 1, previous byte taken as newline, all options off
// a stall on m_axis holds the sequencer in any step that emits a byte

module text_stream_cat_filter #(
    parameter int NUMBER_DIGITS = tscf_pkg::DIGITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // in_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // out_byte
    output logic                           m_axis_tlast,
    input  logic                           cfg_we,
    input  logic [tscf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           cfg_data
);
    import tscf_pkg::*;

    cfg_t  cfg_reg;
    ctrl_t ctrl;
    stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUMBER_NONBLANK:  cfg_reg.number_nonblank  <= cfg_data;
                REG_NUMBER_ALL:       cfg_reg.number_all       <= cfg_data;
                REG_SQUEEZE_BLANK:    cfg_reg.squeeze_blank    <= cfg_data;
                REG_SHOW_ENDS:        cfg_reg.show_ends        <= cfg_data;
                REG_SHOW_TABS:        cfg_reg.show_tabs        <= cfg_data;
                REG_SHOW_NONPRINTING: cfg_reg.show_nonprinting <= cfg_data;
                default:              ;
            endcase
        end
    end

    tscf_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    tscf_dp #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ctrl      (ctrl),
        .stat      (stat),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
